// ===== sv/ccsel_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccsel_pkg
// shared types and constants for the cluster cpu selector
// ----------------------------------------------------------------------------
package ccsel_pkg;

  localparam int NUM_CPUS    = 8;
  localparam int CAP_BITS    = 12;
  localparam int CPU_BITS    = 6;
  localparam int GROUP_BITS  = 23;
  localparam int IGROUP_BITS = 24;
  localparam int WCL_BITS    = 4;
  localparam int CCL_BITS    = 3;
  localparam int CCNT_BITS   = 4;

  // configuration register indexes
  localparam logic CFG_GROUP    = 1'b0;
  localparam logic CFG_CLUSTERS = 1'b1;

  localparam logic [IGROUP_BITS-1:0] IGROUP_RESET = '1;
  localparam logic [CCNT_BITS-1:0]   CCNT_RESET   = CCNT_BITS'(1);

  // one cpu record
  typedef struct packed {
    logic [CPU_BITS-1:0]   cpu_index;
    logic [GROUP_BITS-1:0] task_group;
    logic [WCL_BITS-1:0]   wanted_cluster;
    logic [CCL_BITS-1:0]   cpu_cluster;
    logic                  affinity_ok;
    logic                  cpu_online;
    logic                  cpu_idle;
    logic                  runs_here;
    logic [CAP_BITS-1:0]   capacity;
    logic [CAP_BITS-1:0]   load;
    logic                  last;
  } record_t;

  typedef struct packed {
    logic [IGROUP_BITS-1:0] interested_group;
    logic [CCNT_BITS-1:0]   cluster_count;
  } cfg_t;

  typedef struct packed {
    logic                hit;
    logic [CPU_BITS-1:0] chosen_cpu;
  } result_t;

  // scan progress seen by the top level
  typedef struct packed {
    logic       first_valid;
    logic       best_valid;
    logic       scan_done;
    logic [1:0] cand_count;
  } scan_status_t;

endpackage

// ===== sv/ccsel_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccsel_scan
// per-record candidate test, running best choice and end-of-request verdict
// ----------------------------------------------------------------------------
module ccsel_scan import ccsel_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  record_t      rec,
  input  cfg_t         cfg,
  output result_t      res,
  output scan_status_t status
);

  logic                first_valid, first_valid_next;
  logic [CPU_BITS-1:0] first_cpu, first_cpu_next;
  logic                first_idle, first_idle_next;
  logic                best_valid, best_valid_next;
  logic [CPU_BITS-1:0] best_cpu, best_cpu_next;
  logic [CAP_BITS-1:0] best_spare, best_spare_next;
  logic                best_idle, best_idle_next;
  logic                scan_done, scan_done_next;
  logic [1:0]          cand_count, cand_count_next;  // saturates at two

  logic                req_ok;
  logic                cand;
  logic [CAP_BITS:0]   diff;
  logic [CAP_BITS-1:0] spare;
  logic                tgt_idle;

  always_comb begin
    req_ok = (cfg.interested_group == {1'b0, rec.task_group}) &&
             !rec.wanted_cluster[WCL_BITS-1] &&
             ({1'b0, rec.wanted_cluster[WCL_BITS-2:0]} < cfg.cluster_count);
    cand   = req_ok && (rec.wanted_cluster[WCL_BITS-2:0] == rec.cpu_cluster) &&
             rec.affinity_ok && rec.cpu_online &&
             ({1'b0, rec.cpu_index} < (CPU_BITS+1)'(NUM_CPUS));
    diff   = {1'b0, rec.capacity} - {1'b0, rec.load};
    spare  = diff[CAP_BITS] ? '0 : diff[CAP_BITS-1:0];

    first_valid_next = first_valid;
    first_cpu_next   = first_cpu;
    first_idle_next  = first_idle;
    best_valid_next  = best_valid;
    best_cpu_next    = best_cpu;
    best_spare_next  = best_spare;
    best_idle_next   = best_idle;
    scan_done_next   = scan_done;
    cand_count_next  = cand_count;

    if (cand) begin
      if (cand_count != 2'd2) begin
        cand_count_next = cand_count + 2'd1;
      end
      if (!first_valid) begin
        first_valid_next = 1'b1;
        first_cpu_next   = rec.cpu_index;
        first_idle_next  = rec.cpu_idle;
      end
      if (!scan_done) begin
        if (rec.cpu_idle || rec.runs_here) begin
          best_valid_next = 1'b1;
          best_cpu_next   = rec.cpu_index;
          best_idle_next  = rec.cpu_idle;
          scan_done_next  = 1'b1;
        end else if (spare > best_spare) begin
          best_spare_next = spare;
          best_valid_next = 1'b1;
          best_cpu_next   = rec.cpu_index;
          best_idle_next  = rec.cpu_idle;
        end
      end
    end

    // verdict from the state including this record
    res.hit        = best_valid_next || first_valid_next;
    res.chosen_cpu = best_valid_next ? best_cpu_next : first_cpu_next;
    tgt_idle       = best_valid_next ? best_idle_next : first_idle_next;
    if (cand_count_next == 2'd1 && !tgt_idle) begin
      res.hit = 1'b0;
    end
    if (!req_ok) begin
      res.hit = 1'b0;
    end
    if (!res.hit) begin
      res.chosen_cpu = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_valid <= 1'b0;
      first_idle  <= 1'b0;
      best_valid  <= 1'b0;
      best_spare  <= '0;
      best_idle   <= 1'b0;
      scan_done   <= 1'b0;
      cand_count  <= '0;
    end else if (step) begin
      if (rec.last) begin
        first_valid <= 1'b0;
        first_idle  <= 1'b0;
        best_valid  <= 1'b0;
        best_spare  <= '0;
        best_idle   <= 1'b0;
        scan_done   <= 1'b0;
        cand_count  <= '0;
      end else begin
        first_valid <= first_valid_next;
        first_idle  <= first_idle_next;
        best_valid  <= best_valid_next;
        best_spare  <= best_spare_next;
        best_idle   <= best_idle_next;
        scan_done   <= scan_done_next;
        cand_count  <= cand_count_next;
      end
    end
  end

  // cpu numbers are qualified by their valid bits
  always_ff @(posedge clk) begin
    if (step) begin
      first_cpu <= first_cpu_next;
      best_cpu  <= best_cpu_next;
    end
  end

  assign status = '{first_valid: first_valid, best_valid: best_valid,
                    scan_done: scan_done, cand_count: cand_count};

endmodule

// ===== sv/cluster_cpu_selector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cluster_cpu_selector
// picks a target cpu for a task from a stream of per-cpu records
// ----------------------------------------------------------------------------
// Each request on the slave stream is one cpu record; the record with tlast
// closes the placement request and produces exactly one request on the
// master stream (tuser = hit, tdata = target cpu, zero when there is no hit).
// The block takes one record per clock while the output side is free: each
// record is registered in the input register, then one pass of candidate
// test, spare-capacity subtract and compare updates the running choice; the
// verdict of the last record is registered in the output register.
// The only stall is the output register: while a verdict waits for m_tready,
// one further record can still be held. Configuration writes are always
// taken (cfg_ready is tied high) and should be made between requests.
module cluster_cpu_selector import ccsel_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // record stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // cpu_index[5:0], task_group[28:6], wanted_cluster[32:29], cpu_cluster[35:33],
  // affinity_ok[36], cpu_online[37], cpu_idle[38], runs_here[39],
  // capacity[51:40], load[63:52]
  input  logic [63:0]            s_tdata,
  input  logic                   s_tlast,   // last
  // verdict stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [7:0]             m_tdata,   // chosen_cpu[5:0], zero fill [7:6]
  output logic                   m_tuser,   // hit
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [IGROUP_BITS-1:0] cfg_data
);

  cfg_t         cfg;
  record_t      rec;
  record_t      rec_in;
  logic         rec_valid;
  logic         advance;     // output side free to take the next verdict
  logic         step;
  result_t      res;
  scan_status_t status;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.interested_group <= IGROUP_RESET;
      cfg.cluster_count    <= CCNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GROUP:    cfg.interested_group <= cfg_data;
        CFG_CLUSTERS: cfg.cluster_count    <= cfg_data[CCNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // unpack the record
  always_comb begin
    rec_in.cpu_index      = s_tdata[5:0];
    rec_in.task_group     = s_tdata[28:6];
    rec_in.wanted_cluster = s_tdata[32:29];
    rec_in.cpu_cluster    = s_tdata[35:33];
    rec_in.affinity_ok    = s_tdata[36];
    rec_in.cpu_online     = s_tdata[37];
    rec_in.cpu_idle       = s_tdata[38];
    rec_in.runs_here      = s_tdata[39];
    rec_in.capacity       = s_tdata[51:40];
    rec_in.load           = s_tdata[63:52];
    rec_in.last           = s_tlast;
  end

  // input register: drains whenever the output register can move
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance || !rec_valid;
  assign step     = advance && rec_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (s_tready) begin
      rec_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      rec <= rec_in;
    end
  end

  ccsel_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .rec    (rec),
    .cfg    (cfg),
    .res    (res),
    .status (status)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= step && rec.last;
    end
  end

  always_ff @(posedge clk) begin
    if (step && rec.last) begin
      m_tuser <= res.hit;
      m_tdata <= {2'b00, res.chosen_cpu};
    end
  end

  // scan state is back to empty after a closing record
  a_scan_cleared: assert property (@(posedge clk) disable iff (rst)
    step && rec.last |=> !status.first_valid && !status.best_valid &&
                         !status.scan_done && status.cand_count == 2'd0)
    else $error("scan state not cleared after last record");

  // a hit names a cpu that exists
  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> {1'b0, m_tdata[5:0]} < (CPU_BITS+1)'(NUM_CPUS))
    else $error("hit names a cpu beyond the cpu count");

  // a miss reports cpu zero
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 8'd0)
    else $error("miss with a non-zero target");

  // a best choice always comes with a first candidate
  a_best_has_first: assert property (@(posedge clk) disable iff (rst)
    status.best_valid |-> status.first_valid && status.cand_count != 2'd0)
    else $error("best choice without any candidate");

endmodule

// ===== dv/cluster_cpu_selector_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cluster_cpu_selector_tb
// self-checking bench for the cluster cpu selector
// ----------------------------------------------------------------------------
// Cpu records are streamed into the block with random gaps. A scoreboard
// model follows every accepted record and predicts the verdict of each
// placement request. Verdicts are taken with random back-pressure, and one
// long hold-off fills the block. A short directed table comes first. After
// that come random phases, each with its own register setting.
module cluster_cpu_selector_tb;
  import ccsel_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_TARGET = 450;
  localparam int PHASE_SIZE    = 60;
  localparam logic [GROUP_BITS-1:0] FOREIGN = '1;

  typedef enum logic {ROW_REC, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic                   cfg_idx;
    logic [IGROUP_BITS-1:0] cfg_val;
    record_t                rec;
    logic                   typed;
    result_t                want;
  } stim_row_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [63:0]            s_tdata = '0;
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [7:0]             m_tdata;
  logic                   m_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic                   cfg_index = CFG_GROUP;
  logic [IGROUP_BITS-1:0] cfg_data = '0;

  // register copies
  logic [IGROUP_BITS-1:0] grp_cfg = IGROUP_RESET;
  logic [CCNT_BITS-1:0]   ncl_cfg = CCNT_RESET;

  // running choice of the current placement request
  logic                first_ok = 1'b0;
  logic [CPU_BITS-1:0] first_id = '0;
  logic                first_idle = 1'b0;
  logic                best_ok = 1'b0;
  logic [CPU_BITS-1:0] best_id = '0;
  logic [CAP_BITS-1:0] best_spare = '0;
  logic                best_idle = 1'b0;
  logic                found = 1'b0;
  logic [6:0]          n_cand = '0;

  result_t   verdicts_due[$];
  stim_row_t plan[$];
  int        bad_verdicts = 0;
  int        random_records = 0;
  int        cycle_count = 0;
  bit        no_idle = 1'b0;
  bit        squeeze = 1'b0;

  cluster_cpu_selector dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mostly short gaps, a few long ones, none in burst stretches
  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic group_ok(logic [GROUP_BITS-1:0] grp, logic [WCL_BITS-1:0] wcl);
    // negative group register matches nothing
    return !grp_cfg[IGROUP_BITS-1] && grp_cfg[GROUP_BITS-1:0] == grp &&
           !wcl[WCL_BITS-1] && wcl < ncl_cfg;
  endfunction

  // follows one accepted record, yields a verdict on the closing one
  task automatic choose_cpu(input record_t r, output logic done, output result_t v);
    logic                ok;
    logic                cand;
    logic                hit;
    logic                tidle;
    logic [CPU_BITS-1:0] tgt;
    logic [CAP_BITS-1:0] spare;
    ok = group_ok(r.task_group, r.wanted_cluster);
    cand = ok && r.wanted_cluster[CCL_BITS-1:0] == r.cpu_cluster && r.affinity_ok &&
           r.cpu_online && r.cpu_index < NUM_CPUS;
    if (cand) begin
      if (n_cand != 7'd127) n_cand = n_cand + 7'd1;
      if (!first_ok) begin
        first_ok = 1'b1;
        first_id = r.cpu_index;
        first_idle = r.cpu_idle;
      end
      if (!found) begin
        if (r.cpu_idle || r.runs_here) begin
          best_ok = 1'b1;
          best_id = r.cpu_index;
          best_idle = r.cpu_idle;
          found = 1'b1;
        end else begin
          spare = (r.capacity > r.load) ? r.capacity - r.load : '0;
          if (spare > best_spare) begin
            best_spare = spare;
            best_ok = 1'b1;
            best_id = r.cpu_index;
            best_idle = r.cpu_idle;
          end
        end
      end
    end
    done = r.last;
    v = '0;
    if (r.last) begin
      hit = 1'b0;
      tgt = '0;
      tidle = 1'b0;
      if (best_ok) begin
        hit = 1'b1;
        tgt = best_id;
        tidle = best_idle;
      end else if (first_ok) begin
        hit = 1'b1;
        tgt = first_id;
        tidle = first_idle;
      end
      // a lone busy candidate is no boost
      if (hit && n_cand == 7'd1 && !tidle) hit = 1'b0;
      if (!ok) hit = 1'b0;
      v.hit = hit;
      v.chosen_cpu = hit ? tgt : '0;
      first_ok = 1'b0;
      first_id = '0;
      first_idle = 1'b0;
      best_ok = 1'b0;
      best_id = '0;
      best_spare = '0;
      best_idle = 1'b0;
      found = 1'b0;
      n_cand = '0;
    end
  endtask

  // offers one record and holds it until taken; tvalid stays up for a follow-on
  task automatic offer_record(input record_t r, input logic typed, input result_t want);
    logic    done;
    result_t v;
    int      gap;
    s_tvalid <= 1'b1;
    s_tlast  <= r.last;
    s_tdata  <= {r.load, r.capacity, r.runs_here, r.cpu_idle, r.cpu_online,
                 r.affinity_ok, r.cpu_cluster, r.wanted_cluster, r.task_group,
                 r.cpu_index};
    do @(posedge clk); while (!s_tready);
    choose_cpu(r, done, v);
    if (done) verdicts_due.push_back(typed ? want : v);
    if (r.last) random_records = random_records;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // let every verdict out before touching a register
  task automatic drain();
    s_tvalid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [IGROUP_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_GROUP) grp_cfg = val;
    else ncl_cfg = val[CCNT_BITS-1:0];
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic record_t rec(int cpu, int grp, int wcl, int ccl, int aff, int onl,
                                  int idl, int here, int cap, int ld, int lst);
    record_t r;
    r.cpu_index      = CPU_BITS'(cpu);
    r.task_group     = GROUP_BITS'(grp);
    r.wanted_cluster = WCL_BITS'(wcl);
    r.cpu_cluster    = CCL_BITS'(ccl);
    r.affinity_ok    = 1'(aff);
    r.cpu_online     = 1'(onl);
    r.cpu_idle       = 1'(idl);
    r.runs_here      = 1'(here);
    r.capacity       = CAP_BITS'(cap);
    r.load           = CAP_BITS'(ld);
    r.last           = 1'(lst);
    return r;
  endfunction

  task automatic add_rec(input record_t r, input logic typed, input logic hit, input int cpu);
    stim_row_t row;
    row = '0;
    row.kind = ROW_REC;
    row.rec = r;
    row.typed = typed;
    row.want.hit = hit;
    row.want.chosen_cpu = CPU_BITS'(cpu);
    plan.push_back(row);
  endtask

  task automatic add_cfg(input logic idx, input logic [IGROUP_BITS-1:0] val);
    stim_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.cfg_idx = idx;
    row.cfg_val = val;
    plan.push_back(row);
  endtask

  // one random placement request; noisy ones ignore the register setting
  task automatic run_request(input bit noisy, input int n);
    record_t             r;
    logic [GROUP_BITS-1:0] grp;
    logic [WCL_BITS-1:0] wcl;
    int                  top;
    grp = grp_cfg[IGROUP_BITS-1] ? GROUP_BITS'($urandom) : grp_cfg[GROUP_BITS-1:0];
    top = (ncl_cfg > 8) ? 8 : int'(ncl_cfg);
    if (top > 0 && $urandom_range(9) != 0) wcl = WCL_BITS'($urandom_range(top - 1, 0));
    else wcl = WCL_BITS'($urandom);
    for (int i = 0; i < n; i++) begin
      if (noisy) begin
        r = record_t'(($bits(record_t))'({$urandom, $urandom, $urandom}));
      end else begin
        r.cpu_index = ($urandom_range(9) == 0) ? CPU_BITS'($urandom) :
                                                 CPU_BITS'($urandom_range(7, 0));
        r.task_group = ($urandom_range(9) == 0) ? GROUP_BITS'($urandom) : grp;
        r.wanted_cluster = ($urandom_range(14) == 0) ? WCL_BITS'($urandom) : wcl;
        r.cpu_cluster = ($urandom_range(2) == 0) ? CCL_BITS'($urandom) : wcl[CCL_BITS-1:0];
        r.affinity_ok = $urandom_range(7) != 0;
        r.cpu_online = $urandom_range(7) != 0;
        r.cpu_idle = $urandom_range(4) == 0;
        r.runs_here = $urandom_range(9) == 0;
        r.capacity = CAP_BITS'($urandom);
        // keep spares close so the first-maximum rule gets exercised
        r.load = $urandom_range(1) ? CAP_BITS'($urandom) :
                                     r.capacity - CAP_BITS'($urandom_range(64, 0));
      end
      r.last = (i == n - 1);
      offer_record(r, 1'b0, '0);
      random_records++;
    end
  endtask

  task automatic check_verdict();
    result_t exp;
    if (verdicts_due.size() == 0) begin
      if (bad_verdicts < 10)
        $display("unexpected verdict: hit %0d tdata %0h", m_tuser, m_tdata);
      bad_verdicts++;
    end else begin
      exp = verdicts_due.pop_front();
      if (m_tuser !== exp.hit || m_tdata !== {2'b00, exp.chosen_cpu}) begin
        if (bad_verdicts < 10)
          $display("verdict mismatch: expected hit %0d cpu %0d, got hit %0d tdata %0h",
                   exp.hit, exp.chosen_cpu, m_tuser, m_tdata);
        bad_verdicts++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_verdict();
  end

  // verdict side: random stalls, and one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (squeeze) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        squeeze = 1'b0;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (!no_idle && $urandom_range(3) == 0) stall_left = pick_gap();
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    stim_row_t row;
    int        phase;
    int        start;
    int        gx;
    record_t   r;

    gx = 24'h400000;
    // group register still reads none after reset
    add_rec(rec(0, 0, 0, 0, 1, 1, 1, 1, 4095, 0, 1), 1'b1, 1'b0, 0);
    add_cfg(CFG_GROUP, 24'h000000);
    add_cfg(CFG_CLUSTERS, 24'd1);
    // lone busy candidate is refused, lone idle one taken
    add_rec(rec(0, 0, 0, 0, 1, 1, 0, 0, 4095, 0, 1), 1'b1, 1'b0, 0);
    add_rec(rec(7, 0, 0, 0, 1, 1, 1, 0, 0, 4095, 1), 1'b1, 1'b1, 7);
    add_cfg(CFG_GROUP, IGROUP_BITS'(gx));
    add_cfg(CFG_CLUSTERS, 24'd8);
    // largest spare wins, saturated load gives no spare
    add_rec(rec(1, gx, 3, 3, 1, 1, 0, 0, 100, 50, 0), 1'b0, 1'b0, 0);
    add_rec(rec(2, gx, 3, 3, 1, 1, 0, 0, 4095, 4095, 0), 1'b0, 1'b0, 0);
    add_rec(rec(3, gx, 3, 3, 1, 1, 0, 0, 4095, 0, 1), 1'b0, 1'b0, 0);
    // equal spares keep the earlier cpu
    add_rec(rec(4, gx, 5, 5, 1, 1, 0, 0, 200, 100, 0), 1'b0, 1'b0, 0);
    add_rec(rec(5, gx, 5, 5, 1, 1, 0, 0, 300, 200, 0), 1'b0, 1'b0, 0);
    add_rec(rec(6, gx, 5, 5, 1, 1, 0, 0, 10, 4095, 1), 1'b0, 1'b0, 0);
    // no spare anywhere falls back to the first candidate
    add_rec(rec(2, gx, 0, 0, 1, 1, 0, 0, 0, 0, 0), 1'b0, 1'b0, 0);
    add_rec(rec(5, gx, 0, 0, 1, 1, 0, 0, 5, 9, 1), 1'b0, 1'b0, 0);
    // cpu the task runs on wins, later idle cpu is only counted
    add_rec(rec(0, gx, 7, 7, 1, 1, 0, 0, 50, 40, 0), 1'b0, 1'b0, 0);
    add_rec(rec(1, gx, 7, 7, 1, 1, 0, 1, 0, 0, 0), 1'b0, 1'b0, 0);
    add_rec(rec(2, gx, 7, 7, 1, 1, 1, 0, 0, 0, 1), 1'b0, 1'b0, 0);
    // cpu numbers at or past the cpu count never qualify
    add_rec(rec(63, gx, 1, 1, 1, 1, 1, 1, 4095, 0, 0), 1'b0, 1'b0, 0);
    add_rec(rec(8, gx, 1, 1, 1, 1, 1, 0, 4095, 0, 1), 1'b1, 1'b0, 0);
    // foreign group on an early record only
    add_rec(rec(1, FOREIGN, 2, 2, 1, 1, 1, 0, 0, 0, 0), 1'b0, 1'b0, 0);
    add_rec(rec(2, gx, 2, 2, 1, 1, 0, 0, 300, 100, 1), 1'b0, 1'b0, 0);
    // foreign group on the closing record kills the request
    add_rec(rec(3, gx, 4, 4, 1, 1, 1, 0, 0, 0, 0), 1'b0, 1'b0, 0);
    add_rec(rec(4, FOREIGN, 4, 4, 1, 1, 1, 0, 0, 0, 1), 1'b1, 1'b0, 0);
    // no preferred cluster on the closing record
    add_rec(rec(1, gx, 2, 2, 1, 1, 1, 0, 0, 0, 0), 1'b0, 1'b0, 0);
    add_rec(rec(2, gx, -1, 2, 1, 1, 1, 0, 0, 0, 1), 1'b1, 1'b0, 0);
    // affinity, online and cluster filters
    add_rec(rec(0, gx, 7, 7, 0, 1, 1, 0, 0, 0, 0), 1'b0, 1'b0, 0);
    add_rec(rec(1, gx, 7, 7, 1, 0, 1, 0, 0, 0, 0), 1'b0, 1'b0, 0);
    add_rec(rec(2, gx, 7, 6, 1, 1, 1, 0, 0, 0, 0), 1'b0, 1'b0, 0);
    add_rec(rec(3, gx, 7, 7, 1, 1, 0, 0, 9, 1, 1), 1'b0, 1'b0, 0);
    // no valid cluster at all, most negative preferred cluster
    add_cfg(CFG_CLUSTERS, 24'd0);
    add_rec(rec(0, gx, 0, 0, 1, 1, 1, 1, 0, 0, 1), 1'b1, 1'b0, 0);
    add_rec(rec(0, gx, -8, 0, 1, 1, 1, 1, 0, 0, 1), 1'b1, 1'b0, 0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_CFG) begin
        drain();
        write_reg(row.cfg_idx, row.cfg_val);
      end else begin
        offer_record(row.rec, row.typed, row.want);
      end
    end

    // random phases, each under its own register setting
    random_records = 0;
    phase = 0;
    while (random_records < RANDOM_TARGET) begin
      drain();
      case (phase)
        0: begin
          write_reg(CFG_GROUP, 24'h400000);
          write_reg(CFG_CLUSTERS, 24'd8);
        end
        1: begin
          write_reg(CFG_GROUP, 24'h000001);
          write_reg(CFG_CLUSTERS, 24'd0);
        end
        2: begin
          write_reg(CFG_GROUP, {1'b0, GROUP_BITS'($urandom)});
          write_reg(CFG_CLUSTERS, 24'hFFFFFF);
        end
        3: begin
          write_reg(CFG_GROUP, 24'hFFFFFF);
          write_reg(CFG_CLUSTERS, 24'd4);
        end
        4: begin
          write_reg(CFG_GROUP, 24'h000000);
          write_reg(CFG_CLUSTERS, 24'd1);
        end
        5: begin
          write_reg(CFG_GROUP, 24'h800000);
          write_reg(CFG_CLUSTERS, 24'd3);
        end
        default: begin
          write_reg(CFG_GROUP, ($urandom_range(3) == 0) ? IGROUP_BITS'($urandom) :
                               {1'b0, GROUP_BITS'($urandom)});
          write_reg(CFG_CLUSTERS, IGROUP_BITS'($urandom_range(8, 0)));
        end
      endcase
      start = random_records;
      while (random_records - start < PHASE_SIZE) begin
        no_idle = ($urandom_range(7) == 0);
        run_request($urandom_range(9) == 0, ($urandom_range(9) == 0) ?
                    $urandom_range(16, 7) : $urandom_range(6, 1));
      end
      phase++;
    end

    // one request with more candidates than the counter can hold
    drain();
    no_idle = 1'b0;
    write_reg(CFG_GROUP, 24'h000155);
    write_reg(CFG_CLUSTERS, 24'd8);
    for (int i = 0; i < 129; i++) begin
      r = rec(i % 8, 24'h000155, 6, 6, 1, 1, 0, 0, $urandom, $urandom, (i == 128));
      offer_record(r, 1'b0, '0);
    end

    // verdict side holds off while single-record requests keep coming
    drain();
    no_idle = 1'b1;
    squeeze = 1'b1;
    for (int i = 0; i < 30; i++) begin
      r = rec($urandom_range(7, 0), 24'h000155, 2, 2, 1, 1, $urandom_range(1), 0,
              $urandom, $urandom, 1);
      offer_record(r, 1'b0, '0);
    end
    no_idle = 1'b0;

    drain();
    repeat (10) @(posedge clk);
    if (bad_verdicts == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
